[rtl/hole_fit_allocator_assert.svh]
// assertion macros for the hole fit allocator
`ifndef HOLE_FIT_ALLOCATOR_ASSERT_SVH
`define HOLE_FIT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define HFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hole_fit_allocator: implication failed");

// next-cycle implication, sampled on clk, off during reset
`define HFA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hole_fit_allocator: next-cycle check failed");

`else

`define HFA_ASSERT_IMP(label, ante, cons)
`define HFA_ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/hfa_pkg.sv]
`default_nettype none

package hfa_pkg;

    // table geometry
    localparam int HOLES     = 16;
    localparam int SIZE_BITS = 16;
    localparam int ADDR_W    = (HOLES > 1) ? $clog2(HOLES) : 1;

    // fixed field widths
    localparam int IDX_BITS   = 4;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_DATA_W = 5;
    localparam int TOTAL_BITS = 20;

    // accumulator wide enough for the unsaturated sum of all entries
    localparam int SUM_RAW = SIZE_BITS + ADDR_W + 1;
    localparam int SUM_W   = (SUM_RAW > TOTAL_BITS) ? SUM_RAW : TOTAL_BITS + 1;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // register indexes
    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_HOLE_COUNT = 1'b1;

    // policy codes (anything else behaves as first fit)
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    localparam logic [COUNT_W-1:0] HOLE_COUNT_RST = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } seq_state_t;

    // sequencer to scan unit
    typedef struct packed {
        logic              clear;
        logic              scan_en;
        logic [ADDR_W-1:0] addr;
    } scan_ctrl_t;

    // scan unit result
    typedef struct packed {
        logic                 found;
        logic [ADDR_W-1:0]    pick;
        logic [SIZE_BITS-1:0] best;
        logic [SUM_W-1:0]     sum;
    } scan_res_t;

endpackage

`default_nettype wire

[rtl/hfa_table.sv]
`default_nettype none

module hfa_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         we,
    input  wire logic [hfa_pkg::ADDR_W-1:0]    waddr,
    input  wire logic [hfa_pkg::SIZE_BITS-1:0] wdata,
    input  wire logic [hfa_pkg::ADDR_W-1:0]    raddr,
    output logic      [hfa_pkg::SIZE_BITS-1:0] rdata
);
    import hfa_pkg::*;

    logic [SIZE_BITS-1:0] entry_reg [HOLES];

    // hole size entries, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HOLES; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            entry_reg[waddr] <= wdata;
        end
    end

    // single read port for the scan
    assign rdata = entry_reg[raddr];

endmodule

`default_nettype wire

[rtl/hfa_scan.sv]
`default_nettype none

module hfa_scan (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hfa_pkg::scan_ctrl_t          ctrl,
    input  wire logic [hfa_pkg::POLICY_W-1:0]  policy,
    input  wire logic [hfa_pkg::SIZE_BITS-1:0] req,
    input  wire logic [hfa_pkg::SIZE_BITS-1:0] entry,
    output hfa_pkg::scan_res_t                res
);
    import hfa_pkg::*;

    logic                 found_reg;
    logic [ADDR_W-1:0]    pick_reg;
    logic [SIZE_BITS-1:0] best_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 fits;
    logic                 take;

    // candidate test against the current pick
    always_comb
    begin
        fits = (entry >= req);
        take = fits && (!found_reg
                        || ((policy == POL_BEST) && (entry < best_reg))
                        || ((policy == POL_WORST) && (entry > best_reg)));
    end

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.scan_en && take)
        begin
            found_reg <= 1'b1;
        end
    end

    // pick, its size and the running sum
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.scan_en)
        begin
            sum_reg <= sum_reg + SUM_W'(entry);
            if (take)
            begin
                pick_reg <= ctrl.addr;
                best_reg <= entry;
            end
        end
    end

    assign res.found = found_reg;
    assign res.pick  = pick_reg;
    assign res.best  = best_reg;
    assign res.sum   = sum_reg;

endmodule

`default_nettype wire

[rtl/hfa_seq.sv]
`default_nettype none

module hfa_seq (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_fire,
    input  wire logic [hfa_pkg::ADDR_W:0] n_eff,
    input  wire logic                    out_free,
    output logic                         idle,
    output logic                         finish_fire,
    output hfa_pkg::scan_ctrl_t          ctrl
);
    import hfa_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              last;

    assign last = (({1'b0, addr_reg} + (ADDR_W + 1)'(1)) == n_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (n_eff == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // scan address
    always_comb
    begin
        addr_next = addr_reg;
        if (in_fire)
        begin
            addr_next = '0;
        end
        else if ((state_reg == ST_SCAN) && !last)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    // outputs
    always_comb
    begin
        idle         = (state_reg == ST_IDLE);
        finish_fire  = (state_reg == ST_FINISH) && out_free;
        ctrl.clear   = in_fire;
        ctrl.scan_en = (state_reg == ST_SCAN);
        ctrl.addr    = addr_reg;
    end

endmodule

`default_nettype wire

[rtl/hole_fit_allocator.sv]
// Hole fit allocator: a 16-entry table of free-hole sizes. A load transaction
// (cmd 0) writes one entry; a request transaction (cmd 1) picks a hole by
// fit_policy (first, best or worst fit, ties to the lowest index) among the
// first hole_count entries and shrinks it by the request. Every transaction
// returns one result with the grant, the hole index, the size before the
// cut and the saturated total of free space over the entries in use. One
// shared compare and add unit walks the table one entry per cycle, and
// in_ready is low for the whole of a transaction. The result sits in an
// output register, so the next transaction can be taken while it waits;
// the closing cycle of that next transaction is held for as long as the
// earlier result is still waiting there.
`default_nettype none

`include "hole_fit_allocator_assert.svh"

module hole_fit_allocator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           cmd,
    input  wire logic [hfa_pkg::IDX_BITS-1:0]    hole_index,
    input  wire logic [hfa_pkg::SIZE_BITS-1:0]   size_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                granted,
    output logic      [hfa_pkg::IDX_BITS-1:0]    chosen_index,
    output logic      [hfa_pkg::SIZE_BITS-1:0]   size_before,
    output logic      [hfa_pkg::TOTAL_BITS-1:0]  free_total,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [hfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hfa_pkg::*;

    logic [POLICY_W-1:0]   fit_policy_reg;
    logic [COUNT_W-1:0]    hole_count_reg;
    logic                  cmd_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [SIZE_BITS-1:0]  req_reg;
    logic                  out_valid_reg;
    logic                  granted_reg;
    logic [IDX_BITS-1:0]   chosen_reg;
    logic [SIZE_BITS-1:0]  before_reg;
    logic [TOTAL_BITS-1:0] total_reg;

    logic                  idle;
    logic                  in_fire;
    logic                  out_free;
    logic                  finish_fire;
    logic [ADDR_W:0]       n_eff;
    scan_ctrl_t            ctrl;
    scan_res_t             res;
    logic                  grant;
    logic                  load_we;
    logic                  upd_we;
    logic                  tbl_we;
    logic [ADDR_W-1:0]     tbl_waddr;
    logic [SIZE_BITS-1:0]  tbl_wdata;
    logic [SIZE_BITS-1:0]  entry;
    logic [SUM_W-1:0]      sum_net;
    logic [TOTAL_BITS-1:0] total_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= POL_FIRST;
            hole_count_reg <= HOLE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIT_POLICY: fit_policy_reg <= cfg_data[POLICY_W-1:0];
                REG_HOLE_COUNT: hole_count_reg <= cfg_data[COUNT_W-1:0];
                default:        fit_policy_reg <= fit_policy_reg;
            endcase
        end
    end

    // entries in use, capped at the table depth
    assign n_eff = (32'(hole_count_reg) > HOLES) ? (ADDR_W + 1)'(HOLES)
                                                 : (ADDR_W + 1)'(hole_count_reg);

    // handshakes
    assign in_ready = idle;
    assign in_fire  = in_valid && idle;
    assign out_free = !out_valid_reg || out_ready;

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cmd;
            idx_reg <= hole_index;
            req_reg <= size_value;
        end
    end

    hfa_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .n_eff       (n_eff),
        .out_free    (out_free),
        .idle        (idle),
        .finish_fire (finish_fire),
        .ctrl        (ctrl)
    );

    // table write: load at accept, shrink at finish
    assign grant   = (cmd_reg == CMD_ALLOC) && res.found;
    assign load_we = in_fire && (cmd == CMD_LOAD) && (32'(hole_index) < HOLES);
    assign upd_we  = finish_fire && grant;
    assign tbl_we  = load_we || upd_we;

    always_comb
    begin
        if (load_we)
        begin
            tbl_waddr = ADDR_W'(hole_index);
            tbl_wdata = size_value;
        end
        else
        begin
            tbl_waddr = res.pick;
            tbl_wdata = res.best - req_reg;
        end
    end

    hfa_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (ctrl.addr),
        .rdata (entry)
    );

    hfa_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .policy (fit_policy_reg),
        .req    (req_reg),
        .entry  (entry),
        .res    (res)
    );

    // free total after the cut, saturated
    always_comb
    begin
        sum_net    = grant ? (res.sum - SUM_W'(req_reg)) : res.sum;
        total_next = (sum_net > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_net[TOTAL_BITS-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            granted_reg <= grant;
            before_reg  <= grant ? res.best : '0;
            total_reg   <= total_next;
            if (grant)
            begin
                chosen_reg <= IDX_BITS'(res.pick);
            end
            else if (cmd_reg == CMD_LOAD)
            begin
                chosen_reg <= idx_reg;
            end
            else
            begin
                chosen_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign chosen_index = chosen_reg;
    assign size_before  = before_reg;
    assign free_total   = total_reg;

    // checks
    `HFA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `HFA_ASSERT_IMP(a_fail_zero_size, out_valid && !granted, size_before == '0)
    `HFA_ASSERT_IMP(a_grant_in_range, out_valid && granted, 5'(chosen_index) < hole_count_reg)

endmodule

`default_nettype wire

[verif/hole_alloc_checker.sv]
module hole_alloc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           cmd,
    input  logic [hfa_pkg::IDX_BITS-1:0]   hole_index,
    input  logic [hfa_pkg::SIZE_BITS-1:0]  size_value,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           granted,
    input  logic [hfa_pkg::IDX_BITS-1:0]   chosen_index,
    input  logic [hfa_pkg::SIZE_BITS-1:0]  size_before,
    input  logic [hfa_pkg::TOTAL_BITS-1:0] free_total,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [hfa_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             outstanding
);
    import hfa_pkg::*;

    typedef struct packed {
        logic                  granted;
        logic [IDX_BITS-1:0]   index;
        logic [SIZE_BITS-1:0]  size_prev;
        logic [TOTAL_BITS-1:0] total;
    } alloc_result_t;

    // mirror of the hole table and the two registers
    logic [SIZE_BITS-1:0] hole_mirror [HOLES];
    logic [POLICY_W-1:0]  policy_mirror;
    logic [COUNT_W-1:0]   count_mirror;

    // results still owed by the block, oldest first
    alloc_result_t expected_results [$];
    alloc_result_t oldest;

    // apply one transaction to the mirror and work out its result
    function automatic alloc_result_t predict_allocation(
        input logic                 op,
        input logic [IDX_BITS-1:0]  idx,
        input logic [SIZE_BITS-1:0] amount
    );
        alloc_result_t r;
        int            in_use;
        int            pick;
        int            i;
        bit            found;
        int unsigned   total;
        begin
            r      = '0;
            found  = 1'b0;
            pick   = 0;
            total  = 0;
            in_use = (count_mirror > HOLES) ? HOLES : int'(count_mirror);
            if (op == CMD_LOAD)
            begin
                if (int'(idx) < HOLES)
                    hole_mirror[idx] = amount;
                r.index = idx;
            end
            else
            begin
                // scan the entries in use; lowest index wins on ties
                for (i = 0; i < in_use; i++)
                begin
                    if (hole_mirror[i] >= amount)
                    begin
                        if (!found)
                        begin
                            found = 1'b1;
                            pick  = i;
                        end
                        else if (policy_mirror == POL_BEST && hole_mirror[i] < hole_mirror[pick])
                            pick = i;
                        else if (policy_mirror == POL_WORST && hole_mirror[i] > hole_mirror[pick])
                            pick = i;
                    end
                end
                if (found)
                begin
                    r.granted         = 1'b1;
                    r.index           = IDX_BITS'(pick);
                    r.size_prev       = hole_mirror[pick];
                    hole_mirror[pick] = hole_mirror[pick] - amount;
                end
            end
            // free space over the entries in use, saturated
            for (i = 0; i < in_use; i++)
                total += hole_mirror[i];
            r.total = (total > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(total);
            return r;
        end
    endfunction

    // follow config writes, predict accepted transactions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (hole_mirror[k])
                hole_mirror[k] = '0;
            policy_mirror = POL_FIRST;
            count_mirror  = HOLE_COUNT_RST;
            expected_results.delete();
            outstanding    <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_FIT_POLICY)
                    policy_mirror = cfg_data[POLICY_W-1:0];
                else
                    count_mirror = cfg_data[COUNT_W-1:0];
            end

            // a result at this edge belongs to an earlier transaction
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (granted !== oldest.granted || chosen_index !== oldest.index ||
                        size_before !== oldest.size_prev || free_total !== oldest.total)
                        mismatch_count <= mismatch_count + 1;
                    if (granted !== oldest.granted)
                        $error("granted: expected %0d, got %0d", oldest.granted, granted);
                    if (chosen_index !== oldest.index)
                        $error("chosen_index: expected %0d, got %0d",
                               oldest.index, chosen_index);
                    if (size_before !== oldest.size_prev)
                        $error("size_before: expected %0d, got %0d",
                               oldest.size_prev, size_before);
                    if (free_total !== oldest.total)
                        $error("free_total: expected %0d, got %0d", oldest.total, free_total);
                end
            end

            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        predict_allocation(cmd, hole_index, size_value));

            outstanding <= expected_results.size();
        end
    end

endmodule

[verif/testbench.sv]
module testbench;
    import hfa_pkg::*;

    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 24;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  cmd          = CMD_LOAD;
    logic [IDX_BITS-1:0]   hole_index   = '0;
    logic [SIZE_BITS-1:0]  size_value   = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  granted;
    logic [IDX_BITS-1:0]   chosen_index;
    logic [SIZE_BITS-1:0]  size_before;
    logic [TOTAL_BITS-1:0] free_total;
    logic                  cfg_we       = 1'b0;
    logic                  cfg_index    = REG_FIT_POLICY;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int mismatch_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    hole_fit_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .hole_index   (hole_index),
        .size_value   (size_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .chosen_index (chosen_index),
        .size_before  (size_before),
        .free_total   (free_total),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    hole_alloc_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .hole_index     (hole_index),
        .size_value     (size_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted        (granted),
        .chosen_index   (chosen_index),
        .size_before    (size_before),
        .free_total     (free_total),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one transaction, with random idle cycles in front of it
    task automatic send_txn(
        input logic                 op,
        input logic [IDX_BITS-1:0]  idx,
        input logic [SIZE_BITS-1:0] amount
    );
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid   <= 1'b1;
            cmd        <= op;
            hole_index <= idx;
            size_value <= amount;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    // hold off until every result is back and the block has settled
    task automatic drain;
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_config(
        input logic [POLICY_W-1:0] pol,
        input logic [COUNT_W-1:0]  cnt
    );
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_FIT_POLICY;
            cfg_data  <= CFG_DATA_W'(pol);
            @(posedge clk);
            cfg_index <= REG_HOLE_COUNT;
            cfg_data  <= CFG_DATA_W'(cnt);
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // hole sizes: a mix of small and full-range values, with the extremes
    function automatic logic [SIZE_BITS-1:0] hole_size_draw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return SIZE_BITS'($urandom_range(0, 1023));
            default: return SIZE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] request_size_draw();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5, 6: return SIZE_BITS'($urandom_range(0, 255));
            7, 8:       return SIZE_BITS'($urandom_range(0, 4095));
            default:    return SIZE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // run limit
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int                  issued;
        int                  phase;
        int                  in_use;
        int                  j;
        logic [POLICY_W-1:0] pol;
        logic [COUNT_W-1:0]  cnt;

        issued = 0;
        phase  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: best fit over four entries
        write_config(POL_BEST, 5'd4);
        send_txn(CMD_LOAD, 4'd0, 16'hFFFF);
        send_txn(CMD_LOAD, 4'd1, 16'h0000);
        send_txn(CMD_LOAD, 4'd2, 16'd300);
        send_txn(CMD_LOAD, 4'd3, 16'd300);
        // entry beyond the count, written but not counted
        send_txn(CMD_LOAD, 4'd15, 16'hFFFF);
        // zero-size request takes the empty hole and leaves it unchanged
        send_txn(CMD_ALLOC, 4'd9, 16'd0);
        send_txn(CMD_ALLOC, 4'd0, 16'hFFFF);
        // tie between two equal holes
        send_txn(CMD_ALLOC, 4'd5, 16'd100);
        // nothing fits
        send_txn(CMD_ALLOC, 4'd15, 16'hFFFF);
        send_txn(CMD_LOAD, 4'd2, 16'hAAAA);
        send_txn(CMD_LOAD, 4'd3, 16'h5555);
        send_txn(CMD_ALLOC, 4'd0, 16'h5000);
        drain();

        // count zero: every request fails, total is zero
        write_config(POL_WORST, 5'd0);
        send_txn(CMD_ALLOC, 4'd0, 16'd5);
        send_txn(CMD_ALLOC, 4'd0, 16'd0);
        send_txn(CMD_LOAD, 4'd4, 16'd7);
        drain();

        // spare policy code and an oversized count
        write_config(POL_SPARE, 5'd31);
        send_txn(CMD_ALLOC, 4'd0, 16'd1);
        send_txn(CMD_ALLOC, 4'd0, 16'hFFFF);
        drain();

        // worst fit over the full table
        write_config(POL_WORST, 5'd16);
        for (j = 0; j < HOLES; j++)
            send_txn(CMD_LOAD, IDX_BITS'(j), 16'hFFFF);
        send_txn(CMD_ALLOC, 4'd0, 16'd1);
        send_txn(CMD_ALLOC, 4'd0, 16'd2);

        // random phases: reload the table, then mostly requests
        while (issued < RANDOM_ITEMS)
        begin
            case ((phase / 4) % 4)
                0:       pol = POL_FIRST;
                1:       pol = POL_BEST;
                2:       pol = POL_WORST;
                default: pol = POL_SPARE;
            endcase
            if (phase % 5 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       cnt = 5'd0;
                    1:       cnt = 5'd1;
                    2:       cnt = 5'd16;
                    default: cnt = 5'd31;
                endcase
            end
            else
                cnt = COUNT_W'($urandom_range(1, 16));

            drain();
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            write_config(pol, cnt);

            in_use = (cnt > HOLES) ? HOLES : int'(cnt);
            for (j = 0; j < in_use; j++)
                send_txn(CMD_LOAD, IDX_BITS'(j), hole_size_draw());
            for (j = 0; j < PHASE_ITEMS; j++)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_txn(CMD_ALLOC, IDX_BITS'($urandom_range(0, 15)), request_size_draw());
                else
                    send_txn(CMD_LOAD, IDX_BITS'($urandom_range(0, 15)), hole_size_draw());
            end
            issued += in_use + PHASE_ITEMS;
            phase++;
        end

        drain();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
